// File: hdl/affine_point_transform_assert.svh
// assertion macros shared by the affine point transform rtl
// no dependencies; included by the top level after its declarations
`ifndef AFFINE_POINT_TRANSFORM_ASSERT_SVH
`define AFFINE_POINT_TRANSFORM_ASSERT_SVH

// condition must hold at every edge out of reset
`define APT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("apt assertion failed: invariant");

// consequent must hold at the same edge as the antecedent
`define APT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apt assertion failed: implication");

// consequent must hold after the antecedent, at the delay given by dly
`define APT_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("apt assertion failed: latency");

`endif

// File: hdl/apt_pkg.sv
// shared constants, payload types and register codes of the affine point transform
// no dependencies
package apt_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int COEFF_WIDTH = 21;
    localparam int COEFF_FRAC  = COEFF_WIDTH - 5;
    localparam int COLUMN_WIDTH = 63;
    localparam int CFG_DATA_WIDTH = 63;
    localparam int CFG_IDX_WIDTH = 3;

    localparam int PROD_WIDTH = COORD_WIDTH + COEFF_WIDTH;
    localparam int RND_WIDTH  = PROD_WIDTH - COEFF_FRAC;
    localparam int SUM_WIDTH  = RND_WIDTH + 2;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic [CFG_IDX_WIDTH-1:0] REG_COEFF_X  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COEFF_Y  = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COEFF_Z  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET_Z = 3'd5;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic                          clipped;
    } t_result;

    typedef struct packed {
        logic [COLUMN_WIDTH-1:0]       coeff_for_x;
        logic [COLUMN_WIDTH-1:0]       coeff_for_y;
        logic [COLUMN_WIDTH-1:0]       coeff_for_z;
        logic signed [COORD_WIDTH-1:0] offset_x;
        logic signed [COORD_WIDTH-1:0] offset_y;
        logic signed [COORD_WIDTH-1:0] offset_z;
    } t_cfg;

endpackage

// File: hdl/apt_cfg_regs.sv
// configuration register file: matrix columns and translations
// depends on apt_pkg
module apt_cfg_regs
    import apt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    output t_cfg                      o_cfg
);

    localparam logic [COLUMN_WIDTH-1:0] ONE_COEFF = COLUMN_WIDTH'(1) << COEFF_FRAC;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEFF_X:  n_cfg.coeff_for_x = i_cfg_data[COLUMN_WIDTH-1:0];
                REG_COEFF_Y:  n_cfg.coeff_for_y = i_cfg_data[COLUMN_WIDTH-1:0];
                REG_COEFF_Z:  n_cfg.coeff_for_z = i_cfg_data[COLUMN_WIDTH-1:0];
                REG_OFFSET_X: n_cfg.offset_x    = i_cfg_data[COORD_WIDTH-1:0];
                REG_OFFSET_Y: n_cfg.offset_y    = i_cfg_data[COORD_WIDTH-1:0];
                REG_OFFSET_Z: n_cfg.offset_z    = i_cfg_data[COORD_WIDTH-1:0];
                default: ; // unknown index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // identity matrix, no translation
            r_cfg.coeff_for_x <= ONE_COEFF;
            r_cfg.coeff_for_y <= ONE_COEFF << COEFF_WIDTH;
            r_cfg.coeff_for_z <= ONE_COEFF << (2 * COEFF_WIDTH);
            r_cfg.offset_x    <= '0;
            r_cfg.offset_y    <= '0;
            r_cfg.offset_z    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/apt_axis_lane.sv
// one output axis: three multipliers, rounding, sum with translation, saturation
// depends on apt_pkg; four register stages
module apt_axis_lane
    import apt_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  t_point                        i_point,
    input  logic [COLUMN_WIDTH-1:0]       i_column,
    input  logic signed [COORD_WIDTH-1:0] i_offset,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_coord,
    output logic                          o_sat
);

    localparam logic signed [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(1) << (COEFF_FRAC - 1);

    logic signed [COORD_WIDTH-1:0] w_pt   [3];
    logic signed [COEFF_WIDTH-1:0] w_coef [3];
    logic signed [PROD_WIDTH-1:0]  w_bias [3];

    logic signed [PROD_WIDTH-1:0]  r_prod [3];
    logic signed [RND_WIDTH-1:0]   r_rnd  [3];
    logic signed [SUM_WIDTH-1:0]   r_sum;
    logic signed [SUM_WIDTH-1:0]   n_sum;
    logic signed [COORD_WIDTH-1:0] r_coord;
    logic signed [COORD_WIDTH-1:0] n_coord;
    logic                          r_sat;
    logic                          n_sat;
    logic [3:0]                    r_vld;

    assign w_pt[0] = i_point.point_x;
    assign w_pt[1] = i_point.point_y;
    assign w_pt[2] = i_point.point_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_coef[k] = i_column[k*COEFF_WIDTH +: COEFF_WIDTH];
            w_bias[k] = r_prod[k] + ROUND_HALF;
        end
    end

    // stage 1 multiply, stage 2 round half up
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= PROD_WIDTH'(w_pt[k]) * PROD_WIDTH'(w_coef[k]);
            r_rnd[k]  <= w_bias[k][PROD_WIDTH-1:COEFF_FRAC];
        end
    end

    always_comb begin
        n_sum = SUM_WIDTH'(r_rnd[0]) + SUM_WIDTH'(r_rnd[1])
              + SUM_WIDTH'(r_rnd[2]) + SUM_WIDTH'(i_offset);
    end

    // saturate when the bits above the coordinate width disagree with its sign
    always_comb begin
        n_sat   = 1'b0;
        n_coord = r_sum[COORD_WIDTH-1:0];
        if (r_sum[SUM_WIDTH-1:COORD_WIDTH-1] != {(SUM_WIDTH-COORD_WIDTH+1){1'b0}} &&
            r_sum[SUM_WIDTH-1:COORD_WIDTH-1] != {(SUM_WIDTH-COORD_WIDTH+1){1'b1}}) begin
            n_sat   = 1'b1;
            n_coord = r_sum[SUM_WIDTH-1] ? COORD_MIN : COORD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_coord <= n_coord;
        r_sat   <= n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign o_valid = r_vld[3];
    assign o_coord = r_coord;
    assign o_sat   = r_sat;

endmodule

// File: hdl/affine_point_transform.sv
// affine point transform top level: config registers and three axis lanes
// depends on apt_pkg, apt_cfg_regs, apt_axis_lane, affine_point_transform_assert.svh
//
// usage: a point beat is taken at every rising edge with i_start high and
// o_busy low; o_busy stays low, so a new point can enter every cycle.
// each output is the dot product of the point with one matrix column,
// each product rounded half up, plus the translation, saturated to the
// coordinate range; o_result.clipped flags any saturated coordinate.
// the pipeline registers multiply, round, sum and saturate, one register each;
// throughput is one point per cycle, set by the nine parallel multipliers.
// the result beat sits on o_result for one cycle with o_valid high; the
// receiver cannot stall, so it must take every beat.
// configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data with no wait;
// the user must write it only while no point is in flight, which the block
// itself does not enforce; unknown indexes are ignored. synchronous reset
// empties the pipeline and loads the identity matrix with zero translation.
module affine_point_transform
    import apt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  t_point                    i_point,
    output logic                      o_valid,
    output t_result                   o_result,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data
);

    t_cfg                          w_cfg;
    logic                          w_accept;
    logic                          w_vld_x, w_vld_y, w_vld_z;
    logic signed [COORD_WIDTH-1:0] w_x, w_y, w_z;
    logic                          w_sat_x, w_sat_y, w_sat_z;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    apt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    apt_axis_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_point  (i_point),
        .i_column (w_cfg.coeff_for_x),
        .i_offset (w_cfg.offset_x),
        .o_valid  (w_vld_x),
        .o_coord  (w_x),
        .o_sat    (w_sat_x)
    );

    apt_axis_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_point  (i_point),
        .i_column (w_cfg.coeff_for_y),
        .i_offset (w_cfg.offset_y),
        .o_valid  (w_vld_y),
        .o_coord  (w_y),
        .o_sat    (w_sat_y)
    );

    apt_axis_lane u_lane_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_point  (i_point),
        .i_column (w_cfg.coeff_for_z),
        .i_offset (w_cfg.offset_z),
        .o_valid  (w_vld_z),
        .o_coord  (w_z),
        .o_sat    (w_sat_z)
    );

    assign o_valid          = w_vld_x;
    assign o_result.out_x   = w_x;
    assign o_result.out_y   = w_y;
    assign o_result.out_z   = w_z;
    assign o_result.clipped = w_sat_x || w_sat_y || w_sat_z;

`include "affine_point_transform_assert.svh"

    `APT_ASSERT_ALWAYS(a_lanes_aligned, i_clk, i_rst_n, (w_vld_x == w_vld_y) && (w_vld_x == w_vld_z))
    `APT_ASSERT_DELAY(a_latency, i_clk, i_rst_n, w_accept, 4, o_valid)
    `APT_ASSERT_IMPLY(a_clip_at_limit, i_clk, i_rst_n, o_valid && o_result.clipped, (w_x == COORD_MAX) || (w_x == COORD_MIN) || (w_y == COORD_MAX) || (w_y == COORD_MIN) || (w_z == COORD_MAX) || (w_z == COORD_MIN))

endmodule

// File: sim/affine_point_transform_tb.sv
// self-checking bench for affine_point_transform: directed and random points
// against a fixed-point predictor of the 4x3 matrix transform
// depends on apt_pkg and the affine_point_transform rtl
module affine_point_transform_tb;
    import apt_pkg::*;

    localparam int PIPE_LATENCY = 4;
    localparam int SET_POINTS = 50;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED_HI = 3'd7;
    localparam logic [COEFF_WIDTH-1:0] COEFF_ONE  = COEFF_WIDTH'(1) << COEFF_FRAC;
    localparam logic [COEFF_WIDTH-1:0] COEFF_ZERO = '0;
    localparam logic [COEFF_WIDTH-1:0] COEFF_LSB  = COEFF_WIDTH'(1);
    localparam logic [COEFF_WIDTH-1:0] COEFF_NEG_LSB = '1;
    localparam logic [COEFF_WIDTH-1:0] COEFF_TOP = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
    localparam logic [COEFF_WIDTH-1:0] COEFF_BOTTOM = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
    localparam longint ROUND_HALF = longint'(1) << (COEFF_FRAC - 1);

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic                      o_busy;
    t_point                    i_point = '0;
    logic                      o_valid;
    t_result                   o_result;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_data = '0;

    // predictor copy of the matrix registers, at their reset values
    t_cfg matrix_cfg = '{
        coeff_for_x: {COEFF_ZERO, COEFF_ZERO, COEFF_ONE},
        coeff_for_y: {COEFF_ZERO, COEFF_ONE, COEFF_ZERO},
        coeff_for_z: {COEFF_ONE, COEFF_ZERO, COEFF_ZERO},
        offset_x: '0,
        offset_y: '0,
        offset_z: '0
    };

    t_point  point_queue[$];
    t_result expected_results[$];
    int      sender_gap_pct = 15;
    int      mismatch_count = 0;

    affine_point_transform dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_point    (i_point),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_result transform_point(t_point pt);
        t_result r;
        longint coord [3];
        longint acc;
        logic [COLUMN_WIDTH-1:0] column;
        logic signed [COEFF_WIDTH-1:0] c;
        logic signed [COORD_WIDTH-1:0] axis_out [3];
        coord[0] = longint'($signed(pt.point_x));
        coord[1] = longint'($signed(pt.point_y));
        coord[2] = longint'($signed(pt.point_z));
        r.clipped = 1'b0;
        for (int a = 0; a < 3; a++) begin
            case (a)
                0: begin
                    column = matrix_cfg.coeff_for_x;
                    acc = longint'($signed(matrix_cfg.offset_x));
                end
                1: begin
                    column = matrix_cfg.coeff_for_y;
                    acc = longint'($signed(matrix_cfg.offset_y));
                end
                default: begin
                    column = matrix_cfg.coeff_for_z;
                    acc = longint'($signed(matrix_cfg.offset_z));
                end
            endcase
            // each product rounded half up before it joins the sum
            for (int k = 0; k < 3; k++) begin
                c = column[k*COEFF_WIDTH +: COEFF_WIDTH];
                acc += (coord[k] * longint'(c) + ROUND_HALF) >>> COEFF_FRAC;
            end
            if (acc > longint'(COORD_MAX)) begin
                axis_out[a] = COORD_MAX;
                r.clipped = 1'b1;
            end else if (acc < longint'(COORD_MIN)) begin
                axis_out[a] = COORD_MIN;
                r.clipped = 1'b1;
            end else begin
                axis_out[a] = acc[COORD_WIDTH-1:0];
            end
        end
        r.out_x = axis_out[0];
        r.out_y = axis_out[1];
        r.out_z = axis_out[2];
        return r;
    endfunction

    function automatic logic [COEFF_WIDTH-1:0] pick_coeff();
        logic [COEFF_WIDTH-1:0] c;
        case ($urandom_range(7))
            0: c = COEFF_ZERO;
            1: c = COEFF_TOP;
            2: c = COEFF_BOTTOM;
            3, 4: c = COEFF_WIDTH'($urandom);
            default: c = COEFF_WIDTH'($urandom_range(2 * int'(COEFF_ONE)) - int'(COEFF_ONE));
        endcase
        return c;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] pick_coord();
        logic [COORD_WIDTH-1:0] v;
        case ($urandom_range(9))
            0: v = COORD_MAX;
            1: v = COORD_MIN;
            2: v = '0;
            3, 4, 5: v = COORD_WIDTH'($urandom);
            // within +-16.0
            default: v = COORD_WIDTH'($urandom_range(32'h0020_0000) - 32'h0010_0000);
        endcase
        return v;
    endfunction

    // block until no point is queued, held or in flight, then let the pipe settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (point_queue.size() != 0 || i_start || expected_results.size() != 0);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_COEFF_X:  matrix_cfg.coeff_for_x = data;
            REG_COEFF_Y:  matrix_cfg.coeff_for_y = data;
            REG_COEFF_Z:  matrix_cfg.coeff_for_z = data;
            REG_OFFSET_X: matrix_cfg.offset_x = data[COORD_WIDTH-1:0];
            REG_OFFSET_Y: matrix_cfg.offset_y = data[COORD_WIDTH-1:0];
            REG_OFFSET_Z: matrix_cfg.offset_z = data[COORD_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // offsets carry 63 bits so the ignored upper bits get exercised too
    task automatic load_matrix(logic [COLUMN_WIDTH-1:0] col_x, logic [COLUMN_WIDTH-1:0] col_y,
                               logic [COLUMN_WIDTH-1:0] col_z,
                               logic [CFG_DATA_WIDTH-1:0] off_x,
                               logic [CFG_DATA_WIDTH-1:0] off_y,
                               logic [CFG_DATA_WIDTH-1:0] off_z);
        wait_drained();
        write_reg(REG_COEFF_X, col_x);
        write_reg(REG_COEFF_Y, col_y);
        write_reg(REG_COEFF_Z, col_z);
        write_reg(REG_OFFSET_X, off_x);
        write_reg(REG_OFFSET_Y, off_y);
        write_reg(REG_OFFSET_Z, off_z);
        // writes to indexes past the register file must change nothing
        write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                  CFG_DATA_WIDTH'({$urandom, $urandom}));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_point(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y,
                               logic [COORD_WIDTH-1:0] z);
        t_point p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        point_queue.push_back(p);
    endtask

    task automatic check_field(string name, logic [COORD_WIDTH-1:0] want,
                               logic [COORD_WIDTH-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // driver: one point beat per accepted start, random gaps between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                expected_results.push_back(transform_point(i_point));
            end
            if (!i_start || !o_busy) begin
                if (point_queue.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                    i_start <= 1'b1;
                    i_point <= point_queue.pop_front();
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor: every result beat is taken, the receiver never stalls
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none got %h",
                         $time, o_result);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("out_x", want.out_x, o_result.out_x);
                check_field("out_y", want.out_y, o_result.out_y);
                check_field("out_z", want.out_z, o_result.out_z);
                check_field("clipped", COORD_WIDTH'(want.clipped), COORD_WIDTH'(o_result.clipped));
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity matrix out of reset
        queue_point('0, '0, '0);
        queue_point(COORD_MAX, COORD_MIN, '1);
        queue_point(COORD_MIN, COORD_MAX, 32'd1);
        queue_point(32'h0001_8000, -32'sh0001_8000, 32'h0000_7fff);

        // one-lsb coefficients: nonzero products land on or next to half steps
        load_matrix({COEFF_LSB, COEFF_LSB, COEFF_LSB},
                    {COEFF_NEG_LSB, COEFF_NEG_LSB, COEFF_NEG_LSB},
                    {COEFF_ZERO, COEFF_LSB, COEFF_NEG_LSB},
                    {31'h5a5a_5a5a, 32'hffff_ffff}, {31'h7fff_ffff, 32'h0}, 63'd1);
        queue_point(32'h0000_8000, '0, '0);
        queue_point(-32'sh0000_8000, '0, '0);
        queue_point(32'h0001_7fff, 32'h0000_8000, '0);
        queue_point(-32'sh0001_8000, '0, -32'sh0000_8000);

        // largest coefficients and offsets: overflow upward and downward
        load_matrix({3{COEFF_TOP}}, {3{COEFF_TOP}}, {3{COEFF_TOP}},
                    CFG_DATA_WIDTH'(COORD_MAX), CFG_DATA_WIDTH'(COORD_MAX),
                    CFG_DATA_WIDTH'(COORD_MAX));
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_point('0, '0, '0);
        queue_point(32'd1, '0, '0);

        // most negative coefficients and offsets
        load_matrix({3{COEFF_BOTTOM}}, {3{COEFF_BOTTOM}}, {3{COEFF_BOTTOM}},
                    {31'h0, COORD_MIN}, {31'h7fff_ffff, COORD_MIN}, {31'h0, COORD_MIN});
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
        queue_point('0, '0, '0);
        queue_point('1, '0, '0);

        for (int scheme = 0; scheme < 3; scheme++) begin
            for (int set = 0; set < 3; set++) begin
                load_matrix({pick_coeff(), pick_coeff(), pick_coeff()},
                            {pick_coeff(), pick_coeff(), pick_coeff()},
                            {pick_coeff(), pick_coeff(), pick_coeff()},
                            CFG_DATA_WIDTH'({$urandom, pick_coord()}),
                            CFG_DATA_WIDTH'({$urandom, pick_coord()}),
                            CFG_DATA_WIDTH'({$urandom, pick_coord()}));
                case (scheme)
                    0: sender_gap_pct = 15;
                    1: sender_gap_pct = 62;
                    default: sender_gap_pct = 0;
                endcase
                repeat (SET_POINTS) queue_point(pick_coord(), pick_coord(), pick_coord());
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
